FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the rotation-to-quaternion RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation-to-quaternion core.
// ---------------------------------------------------------------------------
package rmq_pkg;
    localparam int DW = 16;
    localparam int FB = 14;
    // root argument: up to 1 + 3*2^15 in Q14, shifted by FB
    localparam int AW = 18;             // |arg| bits (arg >= 0 after clamp)
    localparam int RW = AW + FB;        // radicand width
    localparam int SW = RW / 2;         // root width
    localparam int NW = DW + 1;         // off-diagonal sum width
    localparam int DIVW = NW - 1 + FB + 1; // dividend width (mag<<FB + s)
    localparam int QW = DIVW;           // quotient width
    // input register + root stages + divide stages + output register
    localparam int LAT = 1 + SW + QW + 1;

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [DW-1:0] qw;
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qz;
        logic                 invalid;
    } quat_t;

    typedef enum logic [1:0] {
        PIV_W = 2'd0,
        PIV_X = 2'd1,
        PIV_Y = 2'd2,
        PIV_Z = 2'd3
    } piv_t;

    // payload carried alongside the root pipeline
    typedef struct packed {
        piv_t                 piv;
        logic signed [NW-1:0] n0;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
    } side_t;

    function automatic logic [DW-1:0] sat_mag(input logic [QW-1:0] mag,
                                              input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        begin
            lim = neg ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
            m = (mag > lim) ? lim : mag;
            sat_mag = neg ? DW'(QW'(0) - m) : DW'(m);
        end
    endfunction
endpackage

FILE: rtl/rmq_sqrt.sv
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic          clk,
    input  logic          adv,
    input  logic [RW-1:0] rad,
    input  side_t         side_in,
    output logic [SW-1:0] root,
    output side_t         side_out
);
    // entry i holds the state after result bit i
    logic [RW-1:0] rem_reg  [SW];
    logic [SW-1:0] root_reg [SW];
    side_t         side_reg [SW];

    for (genvar i = 0; i < SW; i++)
    begin : g_st
        localparam int SH = 2 * (SW - 1 - i);
        logic [RW-1:0] rem_cur;
        logic [SW-1:0] root_cur;
        side_t         side_cur;
        logic [RW-1:0] rem_next;
        logic [SW-1:0] root_next;
        logic [RW+1:0] tsh;

        if (i == 0)
        begin : g_first
            assign rem_cur  = rad;
            assign root_cur = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign rem_cur  = rem_reg[i-1];
            assign root_cur = root_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        always_comb
        begin
            tsh = (RW+2)'({root_cur, 2'b01}) << SH;
            if ({2'b00, rem_cur} >= tsh)
            begin
                rem_next  = RW'({2'b00, rem_cur} - tsh);
                root_next = {root_cur[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_cur;
                root_next = {root_cur[SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign root     = root_reg[SW-1];
    assign side_out = side_reg[SW-1];
endmodule

FILE: rtl/rmq_div.sv
// ---------------------------------------------------------------------------
// rmq_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
(
    input  logic            clk,
    input  logic            adv,
    input  logic [DIVW-1:0] num,
    input  logic [SW:0]     den,
    input  logic            neg_in,
    output logic [QW-1:0]   quo,
    output logic            neg_out
);
    // entry i holds the state after quotient bit i
    logic [DIVW-1:0] rem_reg [QW];
    logic [QW-1:0]   q_reg   [QW];
    logic [SW:0]     d_reg   [QW];
    logic            n_reg   [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_st
        localparam int SH = QW - 1 - i;
        logic [DIVW-1:0]  rem_cur;
        logic [QW-1:0]    q_cur;
        logic [SW:0]      d_cur;
        logic             n_cur;
        logic [DIVW+SW:0] dsh;
        logic [DIVW-1:0]  rem_next;
        logic             bit_q;

        if (i == 0)
        begin : g_first
            assign rem_cur = num;
            assign q_cur   = '0;
            assign d_cur   = den;
            assign n_cur   = neg_in;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[i-1];
            assign q_cur   = q_reg[i-1];
            assign d_cur   = d_reg[i-1];
            assign n_cur   = n_reg[i-1];
        end

        always_comb
        begin
            dsh = (DIVW+SW+1)'(d_cur) << SH;
            bit_q = ((DIVW+SW+1)'(rem_cur) >= dsh);
            rem_next = bit_q ? DIVW'((DIVW+SW+1)'(rem_cur) - dsh) : rem_cur;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= {q_cur[QW-2:0], bit_q};
                d_reg[i]   <= d_cur;
                n_reg[i]   <= n_cur;
            end
        end
    end

    assign quo     = q_reg[QW-1];
    assign neg_out = n_reg[QW-1];
endmodule

FILE: rtl/rotation_matrix_to_quaternion_core.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Q2.14 rotation matrix to unit quaternion, Shepperd's method, pipelined.
// ---------------------------------------------------------------------------
// One matrix transaction per cycle while the output is not stalled. The
// pipeline runs pivot select, square root (one bit per stage), three
// dividers in parallel (one quotient bit per stage) and saturate/output.
// The whole pipeline advances together when the output register is empty
// or being drained, so stall backs up at once and nothing is lost or
// repeated. A divisor of zero (root argument at or below zero) yields
// zeros with invalid set.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  mat_t  in_data,
    output logic  out_valid,
    input  logic  out_stall,
    output quat_t out_data
);
`include "assert_macros.svh"

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    // pipeline moves unless the final stage holds data that is stalled
    assign adv      = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = vld_reg[LAT-1];

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // ---- stage 1: pivot choice, root argument, off-diagonal sums ----
    logic signed [DW+1:0] a00, a11, a22, diag, argc;
    logic signed [NW-1:0] n0c, n1c, n2c;
    piv_t                 pivc;
    logic [RW-1:0]        rad_reg;
    side_t                s1_reg;

    always_comb
    begin
        a00  = (DW+2)'(in_data.m00);
        a11  = (DW+2)'(in_data.m11);
        a22  = (DW+2)'(in_data.m22);
        diag = a00 + a11 + a22;
        if (diag > 0)
        begin
            pivc = PIV_W;
            argc = (DW+2)'(1 <<< FB) + diag;
            n0c = NW'(in_data.m21) - NW'(in_data.m12);
            n1c = NW'(in_data.m02) - NW'(in_data.m20);
            n2c = NW'(in_data.m10) - NW'(in_data.m01);
        end
        else if (a00 > a11 && a00 > a22)
        begin
            pivc = PIV_X;
            argc = (DW+2)'(1 <<< FB) + a00 - a11 - a22;
            n0c = NW'(in_data.m21) - NW'(in_data.m12);
            n1c = NW'(in_data.m01) + NW'(in_data.m10);
            n2c = NW'(in_data.m02) + NW'(in_data.m20);
        end
        else if (a11 > a22)
        begin
            pivc = PIV_Y;
            argc = (DW+2)'(1 <<< FB) + a11 - a00 - a22;
            n0c = NW'(in_data.m02) - NW'(in_data.m20);
            n1c = NW'(in_data.m01) + NW'(in_data.m10);
            n2c = NW'(in_data.m12) + NW'(in_data.m21);
        end
        else
        begin
            pivc = PIV_Z;
            argc = (DW+2)'(1 <<< FB) + a22 - a00 - a11;
            n0c = NW'(in_data.m10) - NW'(in_data.m01);
            n1c = NW'(in_data.m02) + NW'(in_data.m20);
            n2c = NW'(in_data.m12) + NW'(in_data.m21);
        end
        if (argc < 0)
            argc = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg <= {argc[AW-1:0], {FB{1'b0}}};
            s1_reg  <= '{piv: pivc, n0: n0c, n1: n1c, n2: n2c};
        end
    end

    // ---- square root ----
    logic [SW-1:0] s_root;
    side_t         s2;

    rmq_sqrt u_sqrt (
        .clk      (clk),
        .adv      (adv),
        .rad      (rad_reg),
        .side_in  (s1_reg),
        .root     (s_root),
        .side_out (s2)
    );

    // ---- three dividers: |n| * 2^FB + s over t = 2s ----
    logic signed [NW-1:0] nv [3];
    logic [QW-1:0]        quo [3];
    logic                 qneg [3];
    logic [SW:0]          tden;

    assign nv[0] = s2.n0;
    assign nv[1] = s2.n1;
    assign nv[2] = s2.n2;
    assign tden  = {s_root, 1'b0};

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        logic [NW-1:0] mag;
        logic [DIVW-1:0] num;
        always_comb
        begin
            mag = nv[k][NW-1] ? NW'(-nv[k]) : NW'(nv[k]);
            num = (DIVW'(mag) << FB) + DIVW'(s_root);
        end
        rmq_div u_div (
            .clk     (clk),
            .adv     (adv),
            .num     (num),
            .den     (tden),
            .neg_in  (nv[k][NW-1]),
            .quo     (quo[k]),
            .neg_out (qneg[k])
        );
    end

    // pivot choice and root delayed to match the dividers
    piv_t          sd_reg [QW];
    logic [SW-1:0] sr_reg [QW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= s2.piv;
            sr_reg[0] <= s_root;
            for (int j = 1; j < QW; j++)
            begin
                sd_reg[j] <= sd_reg[j-1];
                sr_reg[j] <= sr_reg[j-1];
            end
        end
    end

    // ---- output stage: place pivot, saturate, flag zero divisor ----
    logic [DW-1:0] pv, c0, c1, c2;
    quat_t         res;
    quat_t         out_reg;
    logic [SW-1:0] sf;

    always_comb
    begin
        sf = sr_reg[QW-1];
        pv = sat_mag(QW'((QW'(sf) + QW'(1)) >> 1), 1'b0);
        c0 = sat_mag(quo[0], qneg[0]);
        c1 = sat_mag(quo[1], qneg[1]);
        c2 = sat_mag(quo[2], qneg[2]);
        case (sd_reg[QW-1])
            PIV_W:   res = '{qw: pv, qx: c0, qy: c1, qz: c2, invalid: 1'b0};
            PIV_X:   res = '{qw: c0, qx: pv, qy: c1, qz: c2, invalid: 1'b0};
            PIV_Y:   res = '{qw: c0, qx: c1, qy: pv, qz: c2, invalid: 1'b0};
            default: res = '{qw: c0, qx: c1, qy: c2, qz: pv, invalid: 1'b0};
        endcase
        if (sf == '0)
            res = '{qw: '0, qx: '0, qy: '0, qz: '0, invalid: 1'b1};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign out_data = out_reg;

    `ASSERT_IMPLIES(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall, $stable(out_data))
    `ASSERT_IMPLIES(a_inv_zero, clk, rst_n, out_valid && out_data.invalid,
        out_data.qw == '0 && out_data.qx == '0)
endmodule

FILE: dv/rotation_matrix_to_quaternion_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core_tb
// Self-checking bench for the matrix-to-quaternion core. Directed corner
// matrices, then near-rotations, pivot-tie and raw random matrices, are pushed through
// a bursty sender against a stalling receiver; every output transaction is
// checked field by field against an in-bench fixed-point predictor.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_tb;
    import rmq_pkg::*;

    localparam int  LATENCY     = LAT;
    localparam int  NUM_RANDOM  = 1830;
    localparam int  CYCLE_LIMIT = 400000;
    localparam longint ONE_Q    = 64'sd1 << FB;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    mat_t  in_data;
    logic  out_valid;
    logic  out_stall;
    quat_t out_data;

    mat_t  pending_mats[$];     // matrices waiting to be offered
    quat_t expected_quats[$];   // predicted quaternions, oldest first
    int    error_count;
    int    cycle_count;
    bit    stim_done;
    bit    hold_sender;         // sender pauses while this is set
    bit    long_hold_req;       // receiver long hold-off request
    int    gap_left;
    int    burst_left;
    int    hold_left;

    rotation_matrix_to_quaternion_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Integer square root, floor, bit-by-bit.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = x;
        root = 0;
        b    = 64'd1 << 62;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    function automatic logic [DW-1:0] clamp_q(input longint unsigned mag, input bit neg);
        longint unsigned lim;
        longint unsigned m;
        lim = neg ? (64'd1 << (DW-1)) : ((64'd1 << (DW-1)) - 1);
        m   = (mag > lim) ? lim : mag;
        return neg ? DW'(-m) : DW'(m);
    endfunction

    // n * 2^FB / t, rounded on the magnitude, sign restored, saturated
    function automatic logic [DW-1:0] div_by_pivot(input longint n,
                                                   input longint unsigned t,
                                                   input longint unsigned s);
        bit neg;
        longint unsigned mag;
        neg = (n < 0);
        mag = neg ? longint'(-n) : n;
        return clamp_q(((mag << FB) + s) / t, neg);
    endfunction

    function automatic quat_t matrix_to_quat(input mat_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint diag, arg;
        longint nsum[3];
        piv_t   piv;
        longint unsigned s, t;
        logic [DW-1:0] comp[4];
        quat_t  q;
        int     k;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        diag = a00 + a11 + a22;
        if (diag > 0)
        begin
            piv = PIV_W; arg = ONE_Q + diag;
            nsum[0] = a21 - a12; nsum[1] = a02 - a20; nsum[2] = a10 - a01;
        end
        else if (a00 > a11 && a00 > a22)
        begin
            piv = PIV_X; arg = ONE_Q + a00 - a11 - a22;
            nsum[0] = a21 - a12; nsum[1] = a01 + a10; nsum[2] = a02 + a20;
        end
        else if (a11 > a22)
        begin
            piv = PIV_Y; arg = ONE_Q + a11 - a00 - a22;
            nsum[0] = a02 - a20; nsum[1] = a01 + a10; nsum[2] = a12 + a21;
        end
        else
        begin
            piv = PIV_Z; arg = ONE_Q + a22 - a00 - a11;
            nsum[0] = a10 - a01; nsum[1] = a02 + a20; nsum[2] = a12 + a21;
        end
        if (arg < 0)
            arg = 0;
        s = floor_sqrt(longint'(arg) << FB);
        t = s << 1;
        q = '0;
        if (t == 0)
        begin
            q.invalid = 1'b1;
            return q;
        end
        k = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (i == int'(piv))
                comp[i] = clamp_q((s + 1) >> 1, 1'b0);
            else
            begin
                comp[i] = div_by_pivot(nsum[k], t, s);
                k++;
            end
        end
        q.qw = comp[0]; q.qx = comp[1]; q.qy = comp[2]; q.qz = comp[3];
        q.invalid = 1'b0;
        return q;
    endfunction

    function automatic mat_t diag_mat(input int d0, input int d1, input int d2,
                                      input int off);
        mat_t m;
        m.m00 = DW'(d0); m.m11 = DW'(d1); m.m22 = DW'(d2);
        m.m01 = DW'(off); m.m02 = DW'(-off); m.m10 = DW'(off);
        m.m12 = DW'(off); m.m20 = DW'(-off); m.m21 = DW'(-off);
        return m;
    endfunction

    // Random proper rotation built from a random unit quaternion, then
    // perturbed a little so rounding edges get exercised.
    function automatic mat_t near_rotation();
        real w, x, y, z, nrm;
        real r[9];
        mat_t m;
        int jit;
        w = $urandom_range(0, 20000) - 10000.0;
        x = $urandom_range(0, 20000) - 10000.0;
        y = $urandom_range(0, 20000) - 10000.0;
        z = $urandom_range(0, 20000) - 10000.0;
        nrm = $sqrt(w*w + x*x + y*y + z*z);
        if (nrm < 1.0)
        begin
            w = 1.0; nrm = 1.0;
        end
        w /= nrm; x /= nrm; y /= nrm; z /= nrm;
        r[0] = 1 - 2*(y*y + z*z); r[1] = 2*(x*y - z*w); r[2] = 2*(x*z + y*w);
        r[3] = 2*(x*y + z*w); r[4] = 1 - 2*(x*x + z*z); r[5] = 2*(y*z - x*w);
        r[6] = 2*(x*z - y*w); r[7] = 2*(y*z + x*w); r[8] = 1 - 2*(x*x + y*y);
        jit = $urandom_range(0, 3);
        m.m00 = DW'($rtoi(r[0] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m01 = DW'($rtoi(r[1] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m02 = DW'($rtoi(r[2] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m10 = DW'($rtoi(r[3] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m11 = DW'($rtoi(r[4] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m12 = DW'($rtoi(r[5] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m20 = DW'($rtoi(r[6] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m21 = DW'($rtoi(r[7] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        m.m22 = DW'($rtoi(r[8] * 16384.0) + $urandom_range(0, 2*jit) - jit);
        return m;
    endfunction

    // Random matrix whose diagonal sits near a pivot-selection boundary.
    function automatic mat_t tie_matrix();
        mat_t m;
        int v;
        m = mat_t'((9*DW)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        v = $urandom_range(0, 65535) - 32768;
        case ($urandom_range(0, 3))
            0:
            begin
                m.m00 = DW'(v);
                m.m11 = DW'(v);
            end
            1:
            begin
                m.m11 = DW'(v);
                m.m22 = DW'(v);
            end
            2:
            begin
                m.m00 = DW'(v);
                m.m22 = DW'(v);
                m.m11 = DW'(v);
            end
            default:
            begin
                m.m00 = DW'(v);
                m.m11 = DW'(-v);
                m.m22 = '0;
            end
        endcase
        return m;
    endfunction

    initial
    begin
        mat_t m;
        rst_n         = 1'b0;
        stim_done     = 1'b0;
        hold_sender   = 1'b0;
        long_hold_req = 1'b0;

        // directed corners
        pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));      // identity
        pending_mats.push_back(diag_mat(16384, -16384, -16384, 0));    // x pivot
        pending_mats.push_back(diag_mat(-16384, 16384, -16384, 0));    // y pivot
        pending_mats.push_back(diag_mat(-16384, -16384, 16384, 0));    // z pivot
        pending_mats.push_back(diag_mat(0, 0, 0, 1000));               // zero trace
        pending_mats.push_back(diag_mat(-8192, -8192, -8192, 500));    // all equal -> z
        pending_mats.push_back(diag_mat(100, 100, -300, 7));           // equal m00,m11
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, 0));   // most negative diagonal -> z
        pending_mats.push_back(diag_mat(-16384, 0, 0, 0));             // trace -1
        pending_mats.push_back(diag_mat(32767, 32767, 32767, 32767));  // max trace
        pending_mats.push_back(diag_mat(32767, -32768, -32768, -32768));
        pending_mats.push_back(diag_mat(-32768, 32767, -32768, 32767));
        pending_mats.push_back(diag_mat(-32768, -32768, 32767, -32768));
        pending_mats.push_back(diag_mat(-16000, -200, -200, 32767));   // large off-diagonal
        pending_mats.push_back(diag_mat(-16300, -50, -50, -32768));
        pending_mats.push_back(diag_mat(1, 0, 0, 3));                  // trace 1
        m = '1;  pending_mats.push_back(m);
        m = '0;  pending_mats.push_back(m);
        m = {9{16'h8000}}; pending_mats.push_back(m);
        m = {9{16'h7fff}}; pending_mats.push_back(m);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: m = mat_t'((9*DW)'({$urandom, $urandom, $urandom, $urandom,
                                          $urandom}));
                2:    m = tie_matrix();
                default: m = near_rotation();
            endcase
            pending_mats.push_back(m);
            // one full drain in mid-run
            if (i == NUM_RANDOM / 2)
            begin
                wait (pending_mats.size() == 0);
                hold_sender = 1'b1;
                wait (pending_mats.size() == 0 && expected_quats.size() == 0);
                hold_sender = 1'b0;
            end
            // ask the receiver for a long hold-off while input keeps coming
            if (i == NUM_RANDOM / 4)
                long_hold_req = 1'b1;
        end
        stim_done = 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_quats.push_back(matrix_to_quat(in_data));
            if (in_valid && in_stall)
                ; // payload held
            else if (gap_left > 0 || hold_sender || pending_mats.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= pending_mats.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: random stall pattern, with one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (cycle_count[9:8] == 2'b00)
            out_stall <= 1'b0;          // stall-free stretch
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Monitor: compare each accepted quaternion with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        quat_t exp_q;
        if (!rst_n)
            cycle_count <= 0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_quats.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected transaction %h", $time, out_data);
                end
                else
                begin
                    exp_q = expected_quats.pop_front();
                    if (out_data.qw !== exp_q.qw)
                    begin
                        error_count++;
                        $display("%0t: qw expected %0d actual %0d", $time, exp_q.qw, out_data.qw);
                    end
                    if (out_data.qx !== exp_q.qx)
                    begin
                        error_count++;
                        $display("%0t: qx expected %0d actual %0d", $time, exp_q.qx, out_data.qx);
                    end
                    if (out_data.qy !== exp_q.qy)
                    begin
                        error_count++;
                        $display("%0t: qy expected %0d actual %0d", $time, exp_q.qy, out_data.qy);
                    end
                    if (out_data.qz !== exp_q.qz)
                    begin
                        error_count++;
                        $display("%0t: qz expected %0d actual %0d", $time, exp_q.qz, out_data.qz);
                    end
                    if (out_data.invalid !== exp_q.invalid)
                    begin
                        error_count++;
                        $display("%0t: invalid expected %0b actual %0b", $time,
                                 exp_q.invalid, out_data.invalid);
                    end
                end
            end
        end
    end

    // End of run: drain, settle, then report; or give up at the limit.
    initial
    begin
        error_count = 0;
        fork
            begin
                wait (stim_done && pending_mats.size() == 0 && !in_valid
                      && expected_quats.size() == 0);
                repeat (2 * LATENCY) @(posedge clk);
                if (error_count == 0 && expected_quats.size() == 0)
                    $display("TB_OK");
                else
                    $display("TB_ERROR");
            end
            begin
                wait (cycle_count >= CYCLE_LIMIT);
                $display("TB_ERROR");
            end
        join_any
        $finish;
    end
endmodule
